// ===== rtl/core/bhp_pkg.sv =====
// shared types and constants for the bitstream header parser
package bhp_pkg;

  // input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } bhp_in_t;

  // result beat
  typedef struct packed {
    logic [2:0]  section_number;
    logic [2:0]  byte_role;
    logic [7:0]  payload_value;
    logic [31:0] section_length;
    logic        last_of_section;
    logic [1:0]  status;
  } bhp_out_t;

  // classified beat held in the queue
  typedef struct packed {
    logic       eos;
    logic [7:0] data;
    logic       tag_hit;
    logic [2:0] tag_sec;
  } bhp_item_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } bhp_q_status_t;

  typedef enum logic [2:0] {
    PhPreamble = 3'd0,
    PhTag      = 3'd1,
    PhLength   = 3'd2,
    PhPayload  = 3'd3,
    PhDone     = 3'd4,
    PhError    = 3'd5
  } bhp_phase_e;

  typedef enum logic [2:0] {
    RolePreamble = 3'd0,
    RoleTag      = 3'd1,
    RoleLength   = 3'd2,
    RolePayload  = 3'd3,
    RoleTrailing = 3'd4
  } bhp_role_e;

  typedef enum logic [1:0] {
    StBusy   = 2'd0,
    StDone   = 2'd1,
    StBadTag = 2'd2,
    StTrunc  = 2'd3
  } bhp_status_e;

  localparam logic [7:0] TagFirst       = 8'h61; // 'a'
  localparam logic [7:0] TagLast        = 8'h65; // 'e'
  localparam logic [2:0] SecPreamble    = 3'd0;
  localparam logic [2:0] SecFirst       = 3'd1;
  localparam logic [2:0] SecLast        = 3'd5;
  localparam logic [2:0] SecAfter       = 3'd6;
  localparam logic [2:0] LenBytesShort  = 3'd2;
  localparam logic [2:0] LenBytesLong   = 3'd4;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

endpackage

// ===== rtl/core/bhp_front.sv =====
// front stage: input register and tag classification
module bhp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bhp_pkg::bhp_in_t      in_data_i,
  input  bhp_pkg::bhp_q_status_t q_status_i,
  output logic                  push_o,
  output bhp_pkg::bhp_item_t    push_item_o
);
  import bhp_pkg::*;

  logic      valid_q;
  bhp_item_t item_q, item_d;
  logic      load;
  logic [7:0] tag_off;

  assign push_o      = valid_q & ~q_status_i.full;
  assign in_stall_o  = valid_q & q_status_i.full;
  assign load        = ~valid_q | push_o;
  assign push_item_o = item_q;

  // classify the byte as one of the expected tag letters
  always_comb begin
    tag_off          = in_data_i.data_byte - TagFirst;
    item_d.eos       = in_data_i.end_of_stream;
    item_d.data      = in_data_i.data_byte;
    item_d.tag_hit   = (in_data_i.data_byte >= TagFirst) &&
                       (in_data_i.data_byte <= TagLast);
    item_d.tag_sec   = tag_off[2:0] + SecFirst;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== rtl/core/bhp_fifo.sv =====
// short queue between front and back
module bhp_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  bhp_pkg::bhp_item_t     push_item_i,
  input  logic                   pop_i,
  output bhp_pkg::bhp_item_t     pop_item_o,
  output bhp_pkg::bhp_q_status_t status_o
);
  import bhp_pkg::*;

  bhp_item_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]    cnt_q;

  assign status_o.full      = (cnt_q == QueueCntW'(QueueDepth));
  assign status_o.not_empty = (cnt_q != '0);
  assign pop_item_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/core/bhp_back.sv =====
// back stage: section state machine and result register
module bhp_back #(
  parameter int unsigned PreambleBytes = 13
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bhp_pkg::bhp_q_status_t q_status_i,
  input  bhp_pkg::bhp_item_t     item_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output bhp_pkg::bhp_out_t      out_data_o
);
  import bhp_pkg::*;

  localparam logic [31:0] PreLen = 32'(PreambleBytes);
  localparam bhp_phase_e  PhReset = (PreambleBytes == 0) ? PhTag : PhPreamble;
  localparam logic [2:0]  SecReset = (PreambleBytes == 0) ? SecFirst : SecPreamble;

  bhp_phase_e  phase_q, phase_d;
  logic [2:0]  sec_q, sec_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;
  bhp_status_e err_q, err_d;
  logic        out_valid_q;
  bhp_out_t    out_q, out_d;

  logic        advance;
  logic [31:0] cnt_inc, acc_shift;
  logic [2:0]  len_size;
  logic        pre_done, len_done, pay_done, tag_ok, last_sec;

  assign advance     = ~out_valid_q | ~out_stall_i;
  assign pop_o       = q_status_i.not_empty & advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign cnt_inc   = cnt_q + 32'd1;
  assign acc_shift = {acc_q[23:0], item_i.data};
  assign len_size  = (sec_q == SecLast) ? LenBytesLong : LenBytesShort;
  assign pre_done  = (cnt_inc >= PreLen);
  assign len_done  = (cnt_inc >= 32'(len_size));
  assign pay_done  = (cnt_inc >= acc_q);
  assign tag_ok    = item_i.tag_hit && (item_i.tag_sec == sec_q);
  assign last_sec  = (sec_q >= SecLast);

  // next state
  always_comb begin
    phase_d = phase_q;
    sec_d   = sec_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    err_d   = err_q;
    if (item_i.eos) begin
      if (phase_q != PhDone && phase_q != PhError) begin
        err_d   = StTrunc;
        phase_d = PhError;
      end
    end else begin
      unique case (phase_q)
        PhPreamble: begin
          cnt_d = cnt_inc;
          if (pre_done) begin
            cnt_d   = '0;
            sec_d   = SecFirst;
            phase_d = PhTag;
          end
        end
        PhTag: begin
          if (tag_ok) begin
            cnt_d   = '0;
            acc_d   = '0;
            phase_d = PhLength;
          end else begin
            err_d   = StBadTag;
            phase_d = PhError;
          end
        end
        PhLength: begin
          acc_d = acc_shift;
          cnt_d = cnt_inc;
          if (len_done) begin
            cnt_d = '0;
            if (acc_shift == '0) begin
              sec_d   = last_sec ? SecAfter : sec_q + 3'd1;
              phase_d = last_sec ? PhDone : PhTag;
            end else begin
              phase_d = PhPayload;
            end
          end
        end
        PhPayload: begin
          cnt_d = cnt_inc;
          if (pay_done) begin
            cnt_d   = '0;
            sec_d   = last_sec ? SecAfter : sec_q + 3'd1;
            phase_d = last_sec ? PhDone : PhTag;
          end
        end
        PhDone: begin
        end
        default: begin
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    out_d.section_number  = sec_q;
    out_d.byte_role       = RolePreamble;
    out_d.payload_value   = item_i.data;
    out_d.section_length  = '0;
    out_d.last_of_section = 1'b0;
    out_d.status          = StBusy;
    if (item_i.eos) begin
      out_d.payload_value  = '0;
      out_d.section_length = acc_q;
      if (phase_q == PhDone) begin
        out_d.status = StDone;
      end else if (phase_q == PhError) begin
        out_d.status = err_q;
      end else begin
        out_d.status = StTrunc;
      end
    end else begin
      unique case (phase_q)
        PhPreamble: begin
          out_d.last_of_section = pre_done;
        end
        PhTag: begin
          out_d.byte_role = RoleTag;
          if (!tag_ok) begin
            out_d.status = StBadTag;
          end
        end
        PhLength: begin
          out_d.byte_role      = RoleLength;
          out_d.section_length = acc_shift;
          if (len_done && acc_shift == '0) begin
            out_d.last_of_section = 1'b1;
            out_d.status          = last_sec ? StDone : StBusy;
          end
        end
        PhPayload: begin
          out_d.byte_role      = RolePayload;
          out_d.section_length = acc_q;
          if (pay_done) begin
            out_d.last_of_section = 1'b1;
            out_d.status          = last_sec ? StDone : StBusy;
          end
        end
        PhDone: begin
          out_d.section_number = SecAfter;
          out_d.byte_role      = RoleTrailing;
          out_d.status         = StDone;
        end
        default: begin
          out_d.byte_role = RoleTrailing;
          out_d.status    = err_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhReset;
      sec_q       <= SecReset;
      cnt_q       <= '0;
      acc_q       <= '0;
      err_q       <= StBusy;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        sec_q   <= sec_d;
        cnt_q   <= cnt_d;
        acc_q   <= acc_d;
        err_q   <= err_d;
      end
      if (advance) begin
        out_valid_q <= q_status_i.not_empty;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== rtl/core/bitstream_header_parser_core.sv =====
// top level: tag-length-value header parser for a configuration byte stream
// path: an input beat passes the front register, the queue and the back result register
// throughput: one beat per cycle; the back retires one queued beat each unstalled cycle
// the two-entry queue absorbs output stalls so input stall follows only a full queue
// reset: asynchronous active low; parser returns to the preamble (tag phase if no preamble)
// and all valid flags, queue pointers and the error latch clear
module bitstream_header_parser_core #(
  parameter int unsigned PreambleBytes = 13
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bhp_pkg::bhp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bhp_pkg::bhp_out_t out_data_o
);
  import bhp_pkg::*;

  // front to queue
  logic          push;
  bhp_item_t     push_item;
  // queue to back
  logic          pop;
  bhp_item_t     pop_item;
  bhp_q_status_t q_status;

  // front registers each beat and marks whether it is one of the tag letters,
  // so the back only compares a 3-bit section code against its own index
  bhp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // short queue decouples input acceptance from output stalls
  bhp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .status_o    (q_status)
  );

  // back holds phase, section index, byte counter, length and error latch,
  // and registers the result beat
  bhp_back #(
    .PreambleBytes (PreambleBytes)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
